// ===== hdl/ucwl_pkg.sv =====
// ucwl_pkg: shared types and constants for the card identifier whitelist table
// no dependencies; used by the interfaces, controller, datapath, top level and checker
`timescale 1ns / 1ps

package ucwl_pkg;

    // field widths fixed by the item formats
    localparam int UID_W    = 32;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 3;
    localparam int ENT_W    = 5;

    // default table depth and the card present after reset
    localparam int               P_TABLE_DEPTH = 16;
    localparam logic [UID_W-1:0] P_PRESET_UID  = 32'hD724_5B6A;

    // requested operation; the unused code behaves as a lookup
    typedef enum logic [MODE_W-1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_DELETE = 2'd2
    } t_mode;

    // result codes
    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED   = 3'd0,
        ST_DENIED    = 3'd1,
        ST_ADDED     = 3'd2,
        ST_PRESENT   = 3'd3,
        ST_FULL      = 3'd4,
        ST_DELETED   = 3'd5,
        ST_NOT_FOUND = 3'd6
    } t_status;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPEND,
        S_MOVE_RD,
        S_MOVE_WR,
        S_RESULT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic    load;
        logic    scan;
        logic    append;
        logic    move_rd;
        logic    move_wr;
        logic    status_we;
        t_status status;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic  hit;
        logic  miss;
        logic  not_full;
        t_mode mode;
    } t_sts;

endpackage

// ===== hdl/ucwl_if.sv =====
// ucwl_req_if / ucwl_rsp_if: valid/ready channels for request and result items
// depends on ucwl_pkg for field widths
`timescale 1ns / 1ps

interface ucwl_req_if
    import ucwl_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [UID_W-1:0]  uid;

    modport source (output valid, output mode, output uid, input ready);
    modport sink   (input valid, input mode, input uid, output ready);
endinterface

interface ucwl_rsp_if
    import ucwl_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ENT_W-1:0]    entries_used;

    modport source (output valid, output status, output entries_used, input ready);
    modport sink   (input valid, input status, input entries_used, output ready);
endinterface

// ===== hdl/ucwl_ctrl.sv =====
// ucwl_ctrl: sequencer for scan, append, delete move and result hand-off
// depends on ucwl_pkg (t_state, t_cmd, t_sts)
`timescale 1ns / 1ps

module ucwl_ctrl
    import ucwl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    case (i_sts.mode)
                        MODE_DELETE: n_state = S_MOVE_RD;
                        default:     n_state = S_RESULT;
                    endcase
                end else if (i_sts.miss) begin
                    if (i_sts.mode == MODE_ADD && i_sts.not_full) begin
                        n_state = S_APPEND;
                    end else begin
                        n_state = S_RESULT;
                    end
                end
            end
            S_APPEND:  n_state = S_RESULT;
            S_MOVE_RD: n_state = S_MOVE_WR;
            S_MOVE_WR: n_state = S_RESULT;
            S_RESULT: begin
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // outputs and datapath commands
    always_comb begin
        o_req_ready = 1'b0;
        o_rsp_valid = 1'b0;
        o_cmd       = '0;
        o_cmd.status = ST_GRANTED;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = i_req_valid;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit) begin
                    case (i_sts.mode)
                        MODE_ADD: begin
                            o_cmd.status_we = 1'b1;
                            o_cmd.status    = ST_PRESENT;
                        end
                        MODE_DELETE: begin
                            o_cmd.status_we = 1'b0;
                        end
                        default: begin
                            o_cmd.status_we = 1'b1;
                            o_cmd.status    = ST_GRANTED;
                        end
                    endcase
                end else if (i_sts.miss) begin
                    case (i_sts.mode)
                        MODE_ADD: begin
                            o_cmd.status_we = !i_sts.not_full;
                            o_cmd.status    = ST_FULL;
                        end
                        MODE_DELETE: begin
                            o_cmd.status_we = 1'b1;
                            o_cmd.status    = ST_NOT_FOUND;
                        end
                        default: begin
                            o_cmd.status_we = 1'b1;
                            o_cmd.status    = ST_DENIED;
                        end
                    endcase
                end
            end
            S_APPEND: begin
                o_cmd.append    = 1'b1;
                o_cmd.status_we = 1'b1;
                o_cmd.status    = ST_ADDED;
            end
            S_MOVE_RD: begin
                o_cmd.move_rd = 1'b1;
            end
            S_MOVE_WR: begin
                o_cmd.move_wr   = 1'b1;
                o_cmd.status_we = 1'b1;
                o_cmd.status    = ST_DELETED;
            end
            S_RESULT: begin
                o_rsp_valid = 1'b1;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/ucwl_datapath.sv =====
// ucwl_datapath: identifier memory, entry count, scan pointer, compare and result register
// depends on ucwl_pkg (t_cmd, t_sts, preset identifier)
`timescale 1ns / 1ps

module ucwl_datapath
    import ucwl_pkg::*;
#(
    parameter int TABLE_DEPTH = P_TABLE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [UID_W-1:0]    i_uid,
    output logic [STATUS_W-1:0] o_status,
    output logic [ENT_W-1:0]    o_entries_used
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [UID_W-1:0] mem [0:TABLE_DEPTH-1];

    logic [UID_W-1:0] r_uid;
    t_mode            r_mode;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_idx;
    logic             r_rd_vld;
    logic [AW-1:0]    r_rd_idx;
    logic [UID_W-1:0] r_rd_data;
    logic [AW-1:0]    r_pos;
    logic             r_preset;
    t_status          r_status;

    logic             scan_rd;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [CW-1:0]    last_idx;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [UID_W-1:0] wr_data;
    logic             hit;

    // read and write port selection
    assign last_idx = r_count - CW'(1);
    assign scan_rd  = i_cmd.scan && (r_idx < r_count);
    assign rd_en    = scan_rd || i_cmd.move_rd;
    assign rd_addr  = i_cmd.move_rd ? last_idx[AW-1:0] : r_idx[AW-1:0];
    assign wr_en    = i_cmd.append || i_cmd.move_wr;
    assign wr_addr  = i_cmd.append ? r_count[AW-1:0] : r_pos;
    assign wr_data  = i_cmd.append ? r_uid : r_rd_data;

    // identifier memory; entry 0 reads as the preset card until first written
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            if (rd_addr == '0 && r_preset) begin
                r_rd_data <= P_PRESET_UID;
            end else begin
                r_rd_data <= mem[rd_addr];
            end
        end
    end

    // compare the registered entry against the request identifier
    assign hit = r_rd_vld && (r_rd_data == r_uid);

    assign o_sts.hit      = hit;
    assign o_sts.miss     = (r_idx >= r_count) && !hit;
    assign o_sts.not_full = r_count < CW'(TABLE_DEPTH);
    assign o_sts.mode     = r_mode;

    // count, preset flag and scan pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= CW'(1);
            r_preset <= 1'b1;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= scan_rd;
            if (i_cmd.append) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.move_wr) begin
                r_count <= last_idx;
            end
            if (wr_en && wr_addr == '0) begin
                r_preset <= 1'b0;
            end
        end
    end

    // request latch, scan pointer, hit position and result code
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_uid  <= i_uid;
            r_mode <= t_mode'(i_mode);
            r_idx  <= '0;
        end else if (scan_rd) begin
            r_idx <= r_idx + CW'(1);
        end
        if (scan_rd) begin
            r_rd_idx <= r_idx[AW-1:0];
        end
        if (i_cmd.scan && hit) begin
            r_pos <= r_rd_idx;
        end
        if (i_cmd.status_we) begin
            r_status <= i_cmd.status;
        end
    end

    assign o_status       = r_status;
    assign o_entries_used = ENT_W'(r_count);

endmodule

// ===== hdl/card_uid_whitelist_table.sv =====
// card_uid_whitelist_table: top level joining the sequencer and the datapath
// depends on ucwl_pkg, ucwl_if, ucwl_ctrl and ucwl_datapath
//
//  channel | dir | fields                         | handshake
//  --------+-----+--------------------------------+------------
//  i_req   | in  | mode[1:0], uid[31:0]           | valid/ready
//  o_rsp   | out | status[2:0], entries_used[4:0] | valid/ready
//
// one item at a time: accept, scan of the used entries, optional write, result
// a lookup scans the used entries; an add also appends, a delete also moves the
// last entry into the freed slot; the scan reads one memory entry per cycle
// i_rst_n is synchronous: table holds only the preset card, count is one
// i_req.ready stays low from accept until the result item is taken
`timescale 1ns / 1ps

module card_uid_whitelist_table
    import ucwl_pkg::*;
#(
    parameter int TABLE_DEPTH = P_TABLE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ucwl_req_if.sink          i_req,
    ucwl_rsp_if.source        o_rsp
);

    t_cmd cmd;
    t_sts sts;

    // sequencer
    ucwl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // table storage and compare
    ucwl_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_mode         (i_req.mode),
        .i_uid          (i_req.uid),
        .o_status       (o_rsp.status),
        .o_entries_used (o_rsp.entries_used)
    );

endmodule

// ===== hdl/ucwl_checker.sv =====
// ucwl_checker: port-level assertions for the whitelist table, bound to the top level
// depends on ucwl_pkg (status codes) and card_uid_whitelist_table
`timescale 1ns / 1ps

module ucwl_checker
    import ucwl_pkg::*;
#(
    parameter int TABLE_DEPTH = P_TABLE_DEPTH
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_req_valid,
    input logic                i_req_ready,
    input logic                i_rsp_valid,
    input logic                i_rsp_ready,
    input logic [STATUS_W-1:0] i_status,
    input logic [ENT_W-1:0]    i_entries_used
);

    // no new item is taken while a result waits
    a_no_accept_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !i_req_ready)
        else $error("request ready while a result is pending");

    // an accepted item never produces its result in the next cycle
    a_result_not_immediate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_rsp_valid)
        else $error("result shown one cycle after accept");

    // exactly one result per item
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_ready) |=> !i_rsp_valid)
        else $error("second result without a new item");

    // a full report carries the full count
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_status == ST_FULL) |-> (i_entries_used == ENT_W'(TABLE_DEPTH)))
        else $error("full reported with a count below the depth");

    // stalled result holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_status) && $stable(i_entries_used)))
        else $error("result changed while stalled");

endmodule

bind card_uid_whitelist_table ucwl_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_ucwl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_status       (o_rsp.status),
    .i_entries_used (o_rsp.entries_used)
);

// ===== tb/sv/ucwl_whitelist_checker.sv =====
// ucwl_whitelist_checker: watches the request and result channels of the whitelist table,
// predicts each result item from its own copy of the table and compares field by field
// depends on ucwl_pkg and the ucwl_req_if / ucwl_rsp_if interfaces
`timescale 1ns / 1ps

module ucwl_whitelist_checker
    import ucwl_pkg::*;
#(
    parameter int TABLE_DEPTH = P_TABLE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ucwl_req_if        i_req,
    ucwl_rsp_if        i_rsp,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked,
    output int         o_full_count,
    output int         o_empty_count
);

    // one predicted result item
    typedef struct packed {
        t_status          status;
        logic [ENT_W-1:0] used;
    } t_outcome;

    localparam int MAX_PRINTED = 20;

    logic [UID_W-1:0] card_ids [TABLE_DEPTH];
    int unsigned      shadow_used;
    t_outcome         outcome_q [$];

    // apply one request to the shadow table and return the result it gives
    function automatic t_outcome apply_request(input logic [MODE_W-1:0] mode,
                                               input logic [UID_W-1:0]  uid);
        int       pos;
        t_outcome res;
        pos = -1;
        // first match below the used count
        for (int i = 0; i < int'(shadow_used); i++) begin
            if (pos < 0 && card_ids[i] == uid) begin
                pos = i;
            end
        end
        case (mode)
            MODE_ADD: begin
                // duplicate check comes before the full check
                if (pos >= 0) begin
                    res.status = ST_PRESENT;
                end else if (shadow_used < TABLE_DEPTH) begin
                    card_ids[shadow_used] = uid;
                    shadow_used++;
                    res.status = ST_ADDED;
                end else begin
                    res.status = ST_FULL;
                end
            end
            MODE_DELETE: begin
                // last entry fills the freed slot
                if (pos >= 0) begin
                    card_ids[pos] = card_ids[shadow_used - 1];
                    shadow_used--;
                    res.status = ST_DELETED;
                end else begin
                    res.status = ST_NOT_FOUND;
                end
            end
            default: begin
                // lookup and the spare code
                res.status = (pos >= 0) ? ST_GRANTED : ST_DENIED;
            end
        endcase
        res.used = ENT_W'(shadow_used);
        return res;
    endfunction

    // one line per mismatch, printing capped
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (o_fail_count < MAX_PRINTED) begin
            $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        end
        o_fail_count++;
    endtask

    // predict on accepted requests, compare on accepted results
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                card_ids[i] = '0;
            end
            card_ids[0]   = P_PRESET_UID;
            shadow_used   = 1;
            outcome_q.delete();
            o_fail_count  = 0;
            o_checked     = 0;
            o_full_count  = 0;
            o_empty_count = 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (outcome_q.size() == 0) begin
                    report_mismatch("result item with nothing expected",
                                    32'(i_rsp.status), '0);
                end else begin
                    want = outcome_q.pop_front();
                    if (i_rsp.status !== want.status) begin
                        report_mismatch("status", 32'(i_rsp.status), 32'(want.status));
                    end
                    if (i_rsp.entries_used !== want.used) begin
                        report_mismatch("entries_used", 32'(i_rsp.entries_used),
                                        32'(want.used));
                    end
                    o_checked++;
                end
            end
            if (i_req.valid && i_req.ready) begin
                want = apply_request(i_req.mode, i_req.uid);
                outcome_q.push_back(want);
                if (want.status == ST_FULL) begin
                    o_full_count++;
                end
                if (want.status == ST_DELETED && want.used == 0) begin
                    o_empty_count++;
                end
            end
        end
        o_pending = outcome_q.size();
    end

endmodule

// ===== tb/sv/card_uid_whitelist_table_tb.sv =====
// card_uid_whitelist_table_tb: drives lookup, add and delete items into the whitelist table,
// stalls the result side at random and gives the verdict from the checker's failure count
// depends on ucwl_pkg, the channel interfaces, the table and ucwl_whitelist_checker
`timescale 1ns / 1ps

module card_uid_whitelist_table_tb;
    import ucwl_pkg::*;

    localparam int                TABLE_DEPTH   = P_TABLE_DEPTH;
    localparam logic [MODE_W-1:0] MODE_SPARE    = 2'd3;
    localparam int                POOL_N        = 20;
    localparam int                PHASE_LEN     = 35;
    localparam int                PHASES        = 15;
    localparam int                CALM_FROM     = 12;
    localparam int                LONG_HOLD     = 48;
    localparam int                SETTLE_CYCLES = 40;
    localparam int                STALL_LIMIT   = 1000;

    typedef enum {BIAS_FILL, BIAS_DRAIN, BIAS_MIX} t_bias;

    logic i_clk;
    logic i_rst_n;

    ucwl_req_if req_ch();
    ucwl_rsp_if rsp_ch();

    int fail_count;
    int pending;
    int checked;
    int full_count;
    int empty_count;
    int sent;
    int stall_cycles;
    bit calm;
    bit hold_req;

    logic [UID_W-1:0] card_pool [POOL_N];

    card_uid_whitelist_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    ucwl_whitelist_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_full_count  (full_count),
        .o_empty_count (empty_count)
    );

    // 12 ns clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // result side: short random stalls, one long hold on request
    initial begin : result_sink
        int hold_left;
        bit hold_done;
        hold_left    = 0;
        hold_done    = 1'b0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                rsp_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                hold_left = $urandom_range(0, 2);
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    // offer one request item and hold it until accepted
    task automatic send_req(input logic [MODE_W-1:0] mode, input logic [UID_W-1:0] uid);
        if (!calm && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.mode  <= mode;
        req_ch.uid   <= uid;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    // stop offering until every predicted result has come back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // operation mix per phase
    function automatic logic [MODE_W-1:0] pick_mode(input t_bias bias);
        int r;
        int add_pct;
        int del_pct;
        r = $urandom_range(0, 99);
        case (bias)
            BIAS_FILL:  begin add_pct = 60; del_pct = 15; end
            BIAS_DRAIN: begin add_pct = 15; del_pct = 60; end
            default:    begin add_pct = 30; del_pct = 30; end
        endcase
        if (r < add_pct) return MODE_ADD;
        if (r < add_pct + del_pct) return MODE_DELETE;
        if (r < 94) return MODE_LOOKUP;
        return MODE_SPARE;
    endfunction

    // mostly known cards; unknown and one-bit-off cards only for non-add items
    function automatic logic [UID_W-1:0] pick_uid(input logic [MODE_W-1:0] mode);
        int               r;
        logic [UID_W-1:0] id;
        r  = $urandom_range(0, 99);
        id = card_pool[$urandom_range(0, POOL_N - 1)];
        if (mode != MODE_ADD) begin
            if (r < 10) begin
                id = $urandom();
            end else if (r < 18) begin
                id = id ^ (32'h1 << $urandom_range(0, UID_W - 1));
            end
        end
        return id;
    endfunction

    // stimulus
    initial begin : stimulus
        t_bias            bias;
        int               sweep;
        logic [MODE_W-1:0] mode;
        logic [UID_W-1:0] uid;

        i_rst_n      = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.mode  = MODE_LOOKUP;
        req_ch.uid   = '0;
        calm         = 1'b0;
        hold_req     = 1'b0;
        sent         = 0;

        // card pool: preset card, bit extremes, the rest random
        card_pool[0] = P_PRESET_UID;
        card_pool[1] = '0;
        card_pool[2] = '1;
        card_pool[3] = 32'h8000_0000;
        card_pool[4] = 32'h0000_0001;
        for (int k = 5; k < POOL_N; k++) begin
            card_pool[k] = $urandom();
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: preset card, spare code, empty table, full table, swap on delete
        send_req(MODE_LOOKUP, P_PRESET_UID);
        send_req(MODE_LOOKUP, '0);
        send_req(MODE_SPARE, P_PRESET_UID);
        send_req(MODE_ADD, P_PRESET_UID);
        send_req(MODE_DELETE, '0);
        send_req(MODE_DELETE, P_PRESET_UID);
        send_req(MODE_DELETE, P_PRESET_UID);
        send_req(MODE_SPARE, '1);
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            send_req(MODE_ADD, card_pool[k]);
        end
        send_req(MODE_ADD, card_pool[3]);
        send_req(MODE_ADD, card_pool[TABLE_DEPTH]);
        send_req(MODE_DELETE, card_pool[5]);
        send_req(MODE_LOOKUP, card_pool[TABLE_DEPTH - 1]);
        wait_drained();

        // random phases: fill, drain and mixed, with a pause after each
        for (int ph = 0; ph < PHASES; ph++) begin
            bias  = t_bias'(ph % 3);
            calm  = (ph >= CALM_FROM);
            sweep = $urandom_range(0, POOL_N - 1);
            if (ph == 1) begin
                hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_LEN; n++) begin
                mode = pick_mode(bias);
                // fill and drain walk the pool so the table really fills and empties
                if ((bias == BIAS_FILL && mode == MODE_ADD) ||
                    (bias == BIAS_DRAIN && mode == MODE_DELETE)) begin
                    uid   = card_pool[sweep];
                    sweep = (sweep + 1) % POOL_N;
                end else begin
                    uid = pick_uid(mode);
                end
                send_req(mode, uid);
            end
            wait_drained();
        end

        // let any stray result item show up
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Run covered %0d request items, %0d compared, over fill, drain and mixed phases",
                 sent, checked);
        $display("Table rejected adds as full %0d times and was emptied by delete %0d times",
                 full_count, empty_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
